[rtl/core/adcmma_pkg.sv]
// Shared package for the ADC median / moving-average unit.
// Holds filter sizes, derived widths, beat structs, FSM states and control structs.
// No dependencies.
`default_nettype none

package adcmma_pkg;

  // Filter sizing
  localparam int CHANNELS     = 2;
  localparam int MEDIAN_TAPS  = 5;
  localparam int AVERAGE_TAPS = 8;

  // Field widths
  localparam int CH_W       = 4;
  localparam int RAW_W      = 16;
  localparam int SAMPLE_W   = 12;
  localparam int SAMPLE_MAX = 4095;

  // Derived widths
  localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MP_W        = (MEDIAN_TAPS > 1) ? $clog2(MEDIAN_TAPS) : 1;
  localparam int AP_W        = (AVERAGE_TAPS > 1) ? $clog2(AVERAGE_TAPS) : 1;
  localparam int CNT_W       = $clog2(MEDIAN_TAPS + 1);
  localparam int MEDIAN_RANK = MEDIAN_TAPS / 2;
  localparam int SUM_W       = SAMPLE_W + $clog2(AVERAGE_TAPS + 1);
  localparam int RECIP       = (1 << SUM_W) / AVERAGE_TAPS;
  localparam int PROD_W      = SUM_W + SUM_W + 1;
  localparam int AVG_DEPTH   = CHANNELS * AVERAGE_TAPS;
  localparam int AVG_ADDR_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [RAW_W-1:0] raw_sample;
  } in_beat_t;

  typedef struct packed {
    logic [CH_W-1:0]     result_channel;
    logic [SAMPLE_W-1:0] filtered_value;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MEDIAN,
    ST_ACC,
    ST_MUL,
    ST_QUO,
    ST_FIX,
    ST_DONE
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;
    logic load;
    logic med_step;
    logic acc;
    logic mul;
    logic quo;
    logic fix;
    logic load_out;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_bad;
    logic med_hit;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[rtl/core/adc_median_then_moving_average_unit.sv]
// ADC median / moving-average unit: top level. Depends on adcmma_pkg, adcmma_ctrl, adcmma_dp.
// Each in-range beat takes m = 1..MEDIAN_TAPS rank tests; a beat whose channel is out of range
//   skips straight to the result. One beat is in flight at a time.
// Reset (rst_n low, synchronous): clears the median windows, sums, positions, fill flags and handshakes.
`default_nettype none

module adc_median_then_moving_average_unit (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire adcmma_pkg::in_beat_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output adcmma_pkg::out_beat_t      out_data
);

  // The controller steps each beat through: capture, window update (median row
  // rewrite plus averaging memory read), one rank test per cycle over the
  // median window, running-sum update, then a reciprocal multiply, quotient
  // extract and one-step correction for the division by the averaging length.
  // The finished beat waits in the output register, so the next input beat
  // can be taken while the previous result is still unclaimed.

  adcmma_pkg::cmd_t cmd;
  adcmma_pkg::sts_t sts;

  adcmma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  adcmma_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[rtl/core/adcmma_ctrl.sv]
// Sequencing state machine for the ADC median / moving-average unit.
// Depends on adcmma_pkg (state_t, cmd_t, sts_t).
`default_nettype none

module adcmma_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire adcmma_pkg::sts_t  sts,
  output adcmma_pkg::cmd_t       cmd
);

  adcmma_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= adcmma_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      adcmma_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          // out-of-range channel: skip straight to the result
          state_nxt = sts.in_bad ? adcmma_pkg::ST_DONE : adcmma_pkg::ST_LOAD;
        end
      end
      adcmma_pkg::ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = adcmma_pkg::ST_MEDIAN;
      end
      adcmma_pkg::ST_MEDIAN: begin
        cmd.med_step = 1'b1;
        if (sts.med_hit) begin
          state_nxt = adcmma_pkg::ST_ACC;
        end
      end
      adcmma_pkg::ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = adcmma_pkg::ST_MUL;
      end
      adcmma_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = adcmma_pkg::ST_QUO;
      end
      adcmma_pkg::ST_QUO: begin
        cmd.quo   = 1'b1;
        state_nxt = adcmma_pkg::ST_FIX;
      end
      adcmma_pkg::ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = adcmma_pkg::ST_DONE;
      end
      adcmma_pkg::ST_DONE: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = adcmma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = adcmma_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/adcmma_dp.sv]
// Datapath of the ADC median / moving-average unit: windows, rank search,
// running sums, averaging memory, constant divider and output register.
// Depends on adcmma_pkg.
`default_nettype none

module adcmma_dp (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire adcmma_pkg::in_beat_t  in_data,
  input  wire adcmma_pkg::cmd_t      cmd,
  output adcmma_pkg::sts_t           sts,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output adcmma_pkg::out_beat_t      out_data
);

  localparam int CH_IDX_W   = adcmma_pkg::CH_IDX_W;
  localparam int SAMPLE_W   = adcmma_pkg::SAMPLE_W;
  localparam int MP_W       = adcmma_pkg::MP_W;
  localparam int AP_W       = adcmma_pkg::AP_W;
  localparam int CNT_W      = adcmma_pkg::CNT_W;
  localparam int SUM_W      = adcmma_pkg::SUM_W;
  localparam int PROD_W     = adcmma_pkg::PROD_W;
  localparam int ADDR_W     = adcmma_pkg::AVG_ADDR_W;
  localparam int NCH        = adcmma_pkg::CHANNELS;
  localparam int MTAPS      = adcmma_pkg::MEDIAN_TAPS;
  localparam int ATAPS      = adcmma_pkg::AVERAGE_TAPS;

  // Captured beat
  logic [adcmma_pkg::CH_W-1:0]  ch_r;
  logic [adcmma_pkg::RAW_W-1:0] raw_r;

  // Per-channel state
  logic [SAMPLE_W-1:0] last_valid_r [NCH];
  logic [SAMPLE_W-1:0] med_win_r    [NCH][MTAPS];
  logic [MP_W-1:0]     med_pos_r    [NCH];
  logic [AP_W-1:0]     avg_pos_r    [NCH];
  logic                full_r       [NCH];
  logic [SUM_W-1:0]    sum_r        [NCH];

  // Work registers
  logic [SAMPLE_W-1:0] work_r [MTAPS];
  logic [MP_W-1:0]     cand_r;
  logic [SAMPLE_W-1:0] med_r;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic [SUM_W-1:0]    sum_work_r;
  logic [PROD_W-1:0]   prod_r;
  logic [SAMPLE_W-1:0] quo_r;
  logic [SAMPLE_W-1:0] res_r;
  logic                out_valid_r;
  adcmma_pkg::out_beat_t out_data_r;

  // Averaging window memory
  logic [SAMPLE_W-1:0] avg_mem [adcmma_pkg::AVG_DEPTH];

  logic [CH_IDX_W-1:0] ch_idx;
  logic                raw_ok;
  logic [SAMPLE_W-1:0] sample_nxt;
  logic [MP_W-1:0]     mp, mp_nxt;
  logic [AP_W-1:0]     ap, ap_nxt;
  logic                ap_wrap;
  logic [ADDR_W-1:0]   avg_addr;
  logic [SAMPLE_W-1:0] cand_val;
  logic [MTAPS-1:0]    lt_vec, le_vec;
  logic [CNT_W-1:0]    lt_cnt, le_cnt;
  logic                med_hit;
  logic [SAMPLE_W-1:0] old_val;
  logic [SUM_W-1:0]    sum_nxt;
  logic [SUM_W-1:0]    rem;

  assign ch_idx = ch_r[CH_IDX_W-1:0];
  assign raw_ok = (raw_r <= adcmma_pkg::RAW_W'(adcmma_pkg::SAMPLE_MAX));
  assign sample_nxt = raw_ok ? raw_r[SAMPLE_W-1:0] : last_valid_r[ch_idx];

  assign mp      = med_pos_r[ch_idx];
  assign mp_nxt  = (mp == MP_W'(MTAPS - 1)) ? '0 : mp + 1'b1;
  assign ap      = avg_pos_r[ch_idx];
  assign ap_wrap = (ap == AP_W'(ATAPS - 1));
  assign ap_nxt  = ap_wrap ? '0 : ap + 1'b1;
  assign avg_addr = ADDR_W'(ch_idx) * ADDR_W'(ATAPS) + ADDR_W'(ap);

  // Rank test of one candidate against the whole window
  assign cand_val = work_r[cand_r];
  always_comb begin
    for (int j = 0; j < MTAPS; j++) begin
      lt_vec[j] = (work_r[j] <  cand_val);
      le_vec[j] = (work_r[j] <= cand_val);
    end
  end
  assign lt_cnt  = CNT_W'($countones(lt_vec));
  assign le_cnt  = CNT_W'($countones(le_vec));
  assign med_hit = (lt_cnt <= CNT_W'(adcmma_pkg::MEDIAN_RANK)) &&
                   (le_cnt >  CNT_W'(adcmma_pkg::MEDIAN_RANK));

  // Entry not yet written since reset reads as zero
  assign old_val = full_r[ch_idx] ? rd_data_r : '0;
  assign sum_nxt = sum_r[ch_idx] + SUM_W'(med_r) - SUM_W'(old_val);
  assign rem     = sum_work_r - SUM_W'(quo_r) * SUM_W'(ATAPS);

  assign sts.in_bad   = ({1'b0, in_data.channel} >= (adcmma_pkg::CH_W + 1)'(NCH));
  assign sts.med_hit  = med_hit;
  assign sts.out_free = !out_valid_r || out_ready;

  // Per-channel state with defined reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCH; c++) begin
        last_valid_r[c] <= '0;
        med_pos_r[c]    <= '0;
        avg_pos_r[c]    <= '0;
        full_r[c]       <= 1'b0;
        sum_r[c]        <= '0;
        for (int k = 0; k < MTAPS; k++) begin
          med_win_r[c][k] <= '0;
        end
      end
    end else begin
      if (cmd.load) begin
        last_valid_r[ch_idx]  <= sample_nxt;
        med_win_r[ch_idx][mp] <= sample_nxt;
        med_pos_r[ch_idx]     <= mp_nxt;
      end
      if (cmd.acc) begin
        sum_r[ch_idx]     <= sum_nxt;
        avg_pos_r[ch_idx] <= ap_nxt;
        if (ap_wrap) begin
          full_r[ch_idx] <= 1'b1;
        end
      end
    end
  end

  // Work registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch_r  <= in_data.channel;
      raw_r <= in_data.raw_sample;
      res_r <= '0;
    end
    if (cmd.load) begin
      for (int k = 0; k < MTAPS; k++) begin
        work_r[k] <= (MP_W'(k) == mp) ? sample_nxt : med_win_r[ch_idx][k];
      end
      cand_r <= '0;
    end
    if (cmd.med_step) begin
      if (med_hit) begin
        med_r <= cand_val;
      end else begin
        cand_r <= cand_r + 1'b1;
      end
    end
    if (cmd.acc) begin
      sum_work_r <= sum_nxt;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(sum_work_r) * PROD_W'(adcmma_pkg::RECIP);
    end
    if (cmd.quo) begin
      quo_r <= prod_r[SUM_W +: SAMPLE_W];
    end
    if (cmd.fix) begin
      res_r <= (rem >= SUM_W'(ATAPS)) ? quo_r + 1'b1 : quo_r;
    end
    if (cmd.load_out) begin
      out_data_r.result_channel <= ch_r;
      out_data_r.filtered_value <= res_r;
    end
  end

  // Averaging memory: read while loading, write while accumulating
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_data_r <= avg_mem[avg_addr];
    end
    if (cmd.acc) begin
      avg_mem[avg_addr] <= med_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/core/adcmma_checker.sv]
// Port-level checker for the ADC median / moving-average unit, bound to the top level.
// Depends on adcmma_pkg and adc_median_then_moving_average_unit.
`default_nettype none

module adcmma_checker (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire adcmma_pkg::in_beat_t  in_data,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire adcmma_pkg::out_beat_t out_data
);

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Out-of-range channel yields zero
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ({1'b0, out_data.result_channel} >=
                  (adcmma_pkg::CH_W + 1)'(adcmma_pkg::CHANNELS))
    |-> out_data.filtered_value == '0)
    else $error("out-of-range channel gave a non-zero value");

  // One beat at a time: busy right after taking a beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input taken while a beat is in flight");

  // No result can appear the cycle after a beat is taken
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !$rose(out_valid))
    else $error("result appeared too early");

  // Reset empties the output register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  logic unused_ok;
  assign unused_ok = ^in_data;

endmodule

bind adc_median_then_moving_average_unit adcmma_checker u_adcmma_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
